FILE: design/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants
// Classification record passed from the front end to the back end, status
// codes and chunk type codes.
// ----------------------------------------------------------------------------
`default_nettype none
package pcd_pkg;

  localparam logic [3:0] ST_RUNNING      = 4'd0;
  localparam logic [3:0] ST_DONE         = 4'd1;
  localparam logic [3:0] ST_NOT_PNG      = 4'd2;
  localparam logic [3:0] ST_TOO_SMALL    = 4'd3;
  localparam logic [3:0] ST_BAD_IHDR     = 4'd4;
  localparam logic [3:0] ST_BAD_DEPTH    = 4'd5;
  localparam logic [3:0] ST_BAD_PLTE     = 4'd6;
  localparam logic [3:0] ST_BAD_IEND     = 4'd7;
  localparam logic [3:0] ST_UNKNOWN_CRIT = 4'd8;
  localparam logic [3:0] ST_NO_IHDR      = 4'd9;
  localparam logic [3:0] ST_INCOMPLETE   = 4'd10;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_IDAT = 2'd1;
  localparam logic [1:0] KIND_PLTE = 2'd2;

  localparam logic [31:0] T_IHDR = 32'h49484452;
  localparam logic [31:0] T_PLTE = 32'h504C5445;
  localparam logic [31:0] T_IDAT = 32'h49444154;
  localparam logic [31:0] T_IEND = 32'h49454E44;

  // One classified byte: what the front end decided, plus the raw byte.
  typedef struct packed {
    logic [3:0] status;    // nonzero: this byte finalizes status
    logic [1:0] kind;      // payload forwarding kind
    logic       ihdr_byte; // byte is an IHDR payload byte
    logic [3:0] ihdr_idx;  // index within IHDR payload
    logic       ihdr_last; // last IHDR payload byte
    logic [7:0] data;
  } pcd_item_t;

endpackage
`default_nettype wire

FILE: design/pcd_front.sv
// ----------------------------------------------------------------------------
// pcd_front: chunk framer
// Tracks signature, length, type and CRC fields and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none
module pcd_front
  import pcd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] file_length,
  input  wire logic        in_take,
  input  wire logic [7:0]  file_byte,
  input  wire logic [7:0]  held_depth,
  input  wire logic        saw_header,
  output pcd_item_t        item
);

  typedef enum logic [2:0] {PH_SIG, PH_LEN, PH_TYPE, PH_PAY, PH_CRC, PH_FIN} phase_t;

  phase_t      phase, phase_next;
  logic [31:0] pos;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] clen, clen_next;
  logic [31:0] ctype, ctype_next;
  logic [31:0] rem, rem_next;
  logic [31:0] shift, shift_next;
  logic        first_done, first_done_next;
  logic [32:0] pos1;
  logic [33:0] need;
  logic [31:0] asm_word;
  logic [7:0]  sig_exp;
  logic [3:0]  dlim;
  logic [10:0] plim;
  logic        len_ovf;
  logic        mod3;
  logic [31:0] rem_dec;
  pcd_item_t   it;

  always_comb begin
    case (cnt[2:0])
      3'd0: sig_exp = 8'h89;
      3'd1: sig_exp = 8'h50;
      3'd2: sig_exp = 8'h4E;
      3'd3: sig_exp = 8'h47;
      3'd4: sig_exp = 8'h0D;
      3'd5: sig_exp = 8'h0A;
      3'd6: sig_exp = 8'h1A;
      default: sig_exp = 8'h0A;
    endcase
  end

  // Residue mod 3 of the length: digit sum of base-4 pairs, narrowed twice.
  function automatic logic mod3_nz(input logic [31:0] v);
    logic [6:0] s;
    logic [3:0] t;
    s = '0;
    for (int i = 0; i < 16; i++) s = s + 7'(v[2*i +: 2]);
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]) + 4'(s[6]);
    t = 4'(t[1:0]) + 4'(t[3:2]);
    return !(t == 4'd0 || t == 4'd3 || t == 4'd6);
  endfunction

  always_comb begin
    pos1     = {1'b0, pos} + 33'd1;
    asm_word = {shift[23:0], file_byte};
    need     = {2'b0, pos} + 34'd5 + {2'b0, clen};
    dlim     = (held_depth > 8'd8) ? 4'd8 : held_depth[3:0];
    plim     = 11'd3 << dlim;
    if (LENGTH_BITS >= 32) len_ovf = 1'b0;
    else len_ovf = (clen >> LENGTH_BITS) != 32'd0;
    mod3     = mod3_nz(clen);
    rem_dec  = (rem != 32'd0) ? rem - 32'd1 : 32'd0;

    phase_next      = phase;
    cnt_next        = cnt;
    clen_next       = clen;
    ctype_next      = ctype;
    rem_next        = rem;
    shift_next      = shift;
    first_done_next = first_done;
    it              = '0;
    it.data         = file_byte;

    unique case (phase)
      PH_SIG: begin
        if (file_length < 32'd8 || file_byte != sig_exp) begin
          it.status = ST_NOT_PNG;
        end else if (cnt == 4'd7) begin
          phase_next = PH_LEN;
          cnt_next   = '0;
          if (pos1 >= {1'b0, file_length}) it.status = ST_INCOMPLETE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      PH_LEN, PH_TYPE: begin
        if (cnt == 4'd0 && ({1'b0, pos} + 33'd4) > {1'b0, file_length}) begin
          it.status = ST_TOO_SMALL;
        end else begin
          shift_next = asm_word;
          cnt_next   = cnt + 4'd1;
          if (cnt == 4'd3) begin
            cnt_next = '0;
            if (phase == PH_LEN) begin
              clen_next  = asm_word;
              phase_next = PH_TYPE;
            end else begin
              ctype_next = asm_word;
              rem_next   = clen;
              if (need > {2'b0, file_length} || len_ovf) begin
                it.status = ST_TOO_SMALL;
              end else if (asm_word == T_IHDR && clen != 32'd13) begin
                it.status = ST_BAD_IHDR;
              end else if (asm_word == T_PLTE &&
                           (clen > {21'd0, plim} || mod3)) begin
                it.status = ST_BAD_PLTE;
              end else if (asm_word == T_IEND) begin
                if (clen != 32'd0) it.status = ST_BAD_IEND;
                else if (!first_done && !saw_header) it.status = ST_NO_IHDR;
                else it.status = ST_DONE;
              end else if (asm_word != T_IDAT && asm_word != T_IHDR &&
                           asm_word != T_PLTE && asm_word[31:24] >= 8'h41 &&
                           asm_word[31:24] <= 8'h5A) begin
                it.status = ST_UNKNOWN_CRIT;
              end else if (clen == 32'd0) begin
                if (!first_done && !saw_header) it.status = ST_NO_IHDR;
                else begin
                  first_done_next = 1'b1;
                  phase_next      = PH_CRC;
                end
              end else begin
                phase_next = PH_PAY;
              end
            end
          end
        end
      end
      PH_PAY: begin
        if (ctype == T_IDAT) it.kind = KIND_IDAT;
        else if (ctype == T_PLTE) it.kind = KIND_PLTE;
        else if (ctype == T_IHDR) begin
          it.ihdr_byte = 1'b1;
          it.ihdr_idx  = 4'd13 - ((rem > 32'd13) ? 4'd13 : rem[3:0]);
        end
        rem_next = rem_dec;
        if (rem_dec == 32'd0) begin
          // IHDR end: the back end checks depth; other chunks check the first-chunk rule here
          if (ctype == T_IHDR) it.ihdr_last = 1'b1;
          else if (!first_done && !saw_header) it.status = ST_NO_IHDR;
          if (!(ctype != T_IHDR && !first_done && !saw_header)) begin
            first_done_next = 1'b1;
            phase_next      = PH_CRC;
            cnt_next        = '0;
          end
        end
      end
      PH_CRC: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd3) begin
          phase_next = PH_LEN;
          cnt_next   = '0;
          if (pos1 >= {1'b0, file_length}) it.status = ST_INCOMPLETE;
        end
      end
      default: begin
        it = '0;
      end
    endcase
    if (it.status != ST_RUNNING) phase_next = PH_FIN;
  end

  assign item = it;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIG;
      pos        <= '0;
      cnt        <= '0;
      clen       <= '0;
      ctype      <= '0;
      rem        <= '0;
      shift      <= '0;
      first_done <= 1'b0;
    end else if (in_take && phase != PH_FIN) begin
      phase      <= phase_next;
      cnt        <= cnt_next;
      clen       <= clen_next;
      ctype      <= ctype_next;
      rem        <= rem_next;
      shift      <= shift_next;
      first_done <= first_done_next;
      if (pos != 32'hFFFFFFFF) pos <= pos + 32'd1;
    end
  end

endmodule
`default_nettype wire

FILE: design/pcd_fifo.sv
// ----------------------------------------------------------------------------
// pcd_fifo: two-entry queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pcd_fifo
  import pcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire pcd_item_t wdata,
  output logic           full,
  input  wire logic      pop,
  output pcd_item_t      rdata,
  output logic           not_empty
);

  pcd_item_t  mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign rdata     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/pcd_back.sv
// ----------------------------------------------------------------------------
// pcd_back: result builder
// Captures IHDR fields, checks the bit depth, freezes status, drives outputs.
// ----------------------------------------------------------------------------
`default_nettype none
module pcd_back
  import pcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire pcd_item_t   item,
  output logic             take,
  output logic [7:0]       held_depth,
  output logic             saw_header,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [1:0]       payload_kind,
  output logic [7:0]       payload_byte,
  output logic             header_valid,
  output logic [31:0]      image_width,
  output logic [31:0]      image_height,
  output logic [7:0]       sample_depth,
  output logic [7:0]       colour_kind,
  output logic [7:0]       compression_method,
  output logic [7:0]       filter_method,
  output logic [7:0]       interlace_method
);

  logic [3:0]  fin;
  logic [31:0] w, h;
  logic [7:0]  colr, comp, filt;
  logic [7:0]  depth_new;
  logic [3:0]  st;
  logic        hv;

  assign take = in_valid && (!out_valid || out_ready);

  always_comb begin
    depth_new = (item.ihdr_byte && item.ihdr_idx == 4'd8) ? item.data : held_depth;
    st = item.status;
    hv = 1'b0;
    if (item.ihdr_last) begin
      if ((depth_new & (depth_new - 8'd1)) != 8'd0 || depth_new > 8'd8)
        st = ST_BAD_DEPTH;
      else hv = 1'b1;
    end
    if (fin != ST_RUNNING) st = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin        <= ST_RUNNING;
      out_valid  <= 1'b0;
      held_depth <= '0;
      saw_header <= 1'b0;
      w <= '0; h <= '0; colr <= '0; comp <= '0; filt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        out_valid <= 1'b1;
        fin       <= st;
        status    <= st;
        payload_kind <= (st == ST_RUNNING) ? item.kind : KIND_NONE;
        payload_byte <= (st == ST_RUNNING && item.kind != KIND_NONE) ? item.data : 8'd0;
        header_valid <= (st == ST_RUNNING) && hv;
        image_width  <= '0; image_height <= '0; sample_depth <= '0;
        colour_kind  <= '0; compression_method <= '0;
        filter_method <= '0; interlace_method <= '0;
        if (fin == ST_RUNNING && item.ihdr_byte) begin
          if (item.ihdr_idx < 4'd4) w <= {w[23:0], item.data};
          else if (item.ihdr_idx < 4'd8) h <= {h[23:0], item.data};
          else if (item.ihdr_idx == 4'd8) held_depth <= item.data;
          else if (item.ihdr_idx == 4'd9) colr <= item.data;
          else if (item.ihdr_idx == 4'd10) comp <= item.data;
          else if (item.ihdr_idx == 4'd11) filt <= item.data;
        end
        if (fin == ST_RUNNING && hv) begin
          saw_header         <= 1'b1;
          image_width        <= w;
          image_height       <= h;
          sample_depth       <= depth_new;
          colour_kind        <= colr;
          compression_method <= comp;
          filter_method      <= filt;
          interlace_method   <= item.data;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/png_chunk_deframer_top.sv
// ----------------------------------------------------------------------------
// png_chunk_deframer_top: PNG chunk deframer
// Checks the signature, frames chunks, validates IHDR/PLTE/IEND, forwards data.
// ----------------------------------------------------------------------------
//   channel | signals                          | dir
//   input   | in_valid, in_ready, file_byte     | in
//   output  | out_valid, out_ready, status ...  | out
//   config  | cfg_we, cfg_wdata (file_length)   | in
//
// One byte per cycle while out_ready stays high; each input transaction yields one output
// transaction, registered first in the queue and then in the back end's output register.
// The front end classifies a byte in the cycle it is taken and pushes it into
// a two-entry queue; the back end drains it into the output register.
// in_ready drops only when the queue is full. Reset is synchronous; the
// IHDR depth and header flag fed back from the back end can miss the last
// two bytes taken (still queued), which is safe because at least twelve
// bytes separate an IHDR byte from the next chunk type check.
// ----------------------------------------------------------------------------
`default_nettype none
module png_chunk_deframer_top
  import pcd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  file_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [1:0]       payload_kind,
  output logic [7:0]       payload_byte,
  output logic             header_valid,
  output logic [31:0]      image_width,
  output logic [31:0]      image_height,
  output logic [7:0]       sample_depth,
  output logic [7:0]       colour_kind,
  output logic [7:0]       compression_method,
  output logic [7:0]       filter_method,
  output logic [7:0]       interlace_method
);

  logic [31:0] file_length;
  logic        q_full, q_ne, take;
  pcd_item_t   f_item, q_item;
  logic [7:0]  held_depth;
  logic        saw_header;

  always_ff @(posedge clk) begin
    if (rst) file_length <= '0;
    else if (cfg_we) file_length <= cfg_wdata;
  end

  assign in_ready = !q_full;

  pcd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst, .file_length, .in_take(in_valid && in_ready), .file_byte,
    .held_depth, .saw_header, .item(f_item)
  );

  pcd_fifo u_fifo (
    .clk, .rst, .push(in_valid && in_ready), .wdata(f_item), .full(q_full),
    .pop(take), .rdata(q_item), .not_empty(q_ne)
  );

  pcd_back u_back (
    .clk, .rst, .in_valid(q_ne), .item(q_item), .take, .held_depth, .saw_header,
    .out_valid, .out_ready, .status, .payload_kind, .payload_byte, .header_valid,
    .image_width, .image_height, .sample_depth, .colour_kind, .compression_method,
    .filter_method, .interlace_method
  );

`ifndef SYNTHESIS
  // Header fields only appear on a running header transaction.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && header_valid |-> status == ST_RUNNING)
    else $error("header_valid with final status");
  // A final status never changes on later output.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RUNNING && out_ready ##1 out_valid |-> status == $past(status))
    else $error("final status changed");
  // Payload forwarding never accompanies a final status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RUNNING |-> payload_kind == KIND_NONE)
    else $error("payload with final status");
`endif

endmodule
`default_nettype wire
